@@ hw/rtl/pmct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmct_pkg: shared types and constants
// Types and constants used by the mouse packet front end, the packet queue
// and the cursor back end.
// ----------------------------------------------------------------------------
package pmct_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned CFG_BITS       = 13;
  localparam int unsigned DELTA_BITS     = 10;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [CFG_BITS-1:0] WIDTH_RST  = 13'd1024;
  localparam logic [CFG_BITS-1:0] HEIGHT_RST = 13'd768;

  // Header byte bit positions.
  localparam int unsigned HDR_LEFT   = 0;
  localparam int unsigned HDR_RIGHT  = 1;
  localparam int unsigned HDR_MIDDLE = 2;
  localparam int unsigned HDR_SYNC   = 3;
  localparam int unsigned HDR_XSIGN  = 4;
  localparam int unsigned HDR_YSIGN  = 5;
  localparam int unsigned HDR_XOVF   = 6;
  localparam int unsigned HDR_YOVF   = 7;

  localparam logic signed [DELTA_BITS-1:0] OVF_EXTRA = 10'sd255;

  typedef enum logic {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_DELTA_X = 2'd1,
    PH_DELTA_Y = 2'd2
  } phase_e;

  // One framed packet, ready for the cursor update.
  typedef struct packed {
    logic signed [DELTA_BITS-1:0] dx;
    logic signed [DELTA_BITS-1:0] dy;
    logic                         left;
    logic                         right;
    logic                         middle;
  } pkt_t;

endpackage

@@ hw/rtl/ps2_mouse_packet_cursor_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker: PS/2 mouse packet decoder and cursor
// Frames mouse bytes into packets and tracks a clamped cursor position.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+--------------------------
//   in      | input     | in_valid_i / in_stall_o  | rx_byte_i
//   out     | output    | out_valid_o / out_stall_i| cursor_x/y, buttons
//   cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// One byte is accepted per cycle while the queue has room. A packet's third
// byte writes it into the queue, where it waits at the head while the
// add-and-clamp logic works out the cursor for the output register.
// Reset drops the framer to the header phase, arms the first-byte discard,
// zeroes the cursor and loads the default 1024 x 768 screen size.
// Input stalls only while the two-entry packet queue is full.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker import pmct_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CFG_BITS-1:0]  cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CoordBits-1:0] cursor_x_o,
  output logic [CoordBits-1:0] cursor_y_o,
  output logic                 left_button_o,
  output logic                 right_button_o,
  output logic                 middle_button_o
);

  logic [CFG_BITS-1:0] width_q, height_q;
  logic                push, pop, q_full, q_empty;
  pkt_t                push_pkt, pop_pkt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_SCREEN_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pmct_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_pkt_o (push_pkt)
  );

  pmct_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_pkt_i (push_pkt),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .pop_pkt_o  (pop_pkt)
  );

  pmct_back #(
    .CoordBits (CoordBits)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .width_i         (width_q),
    .height_i        (height_q),
    .q_empty_i       (q_empty),
    .q_pkt_i         (pop_pkt),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cursor_x_o      (cursor_x_o),
    .cursor_y_o      (cursor_y_o),
    .left_button_o   (left_button_o),
    .right_button_o  (right_button_o),
    .middle_button_o (middle_button_o)
  );

endmodule

@@ hw/rtl/pmct_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmct_front: byte framer
// Drops the first byte after reset, frames three-byte packets on the sync bit
// of the header and hands finished packets with decoded deltas to the queue.
// ----------------------------------------------------------------------------
module pmct_front import pmct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       q_full_i,
  output logic       push_o,
  output pkt_t       push_pkt_o
);

  phase_e     phase_q, phase_d;
  logic       discard_q;
  logic [7:0] header_q;
  logic [7:0] delta_x_q;
  logic       accept;

  function automatic logic signed [DELTA_BITS-1:0] signed_delta(
    input logic [7:0] b,
    input logic       neg,
    input logic       ovf
  );
    logic signed [DELTA_BITS-1:0] d;
    d = $signed({{(DELTA_BITS-8){neg}}, b});
    if (ovf) begin
      d = neg ? (d - OVF_EXTRA) : (d + OVF_EXTRA);
    end
    return d;
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    phase_d = phase_q;
    push_o  = 1'b0;
    if (accept && !discard_q) begin
      unique case (phase_q)
        PH_DELTA_X: phase_d = PH_DELTA_Y;
        PH_DELTA_Y: begin
          phase_d = PH_HEADER;
          push_o  = 1'b1;
        end
        default: begin
          phase_d = rx_byte_i[HDR_SYNC] ? PH_DELTA_X : PH_HEADER;
        end
      endcase
    end
  end

  assign push_pkt_o.dx     = signed_delta(delta_x_q, header_q[HDR_XSIGN], header_q[HDR_XOVF]);
  assign push_pkt_o.dy     = signed_delta(rx_byte_i, header_q[HDR_YSIGN], header_q[HDR_YOVF]);
  assign push_pkt_o.left   = header_q[HDR_LEFT];
  assign push_pkt_o.right  = header_q[HDR_RIGHT];
  assign push_pkt_o.middle = header_q[HDR_MIDDLE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      discard_q <= 1'b1;
      header_q  <= '0;
      delta_x_q <= '0;
    end else begin
      phase_q <= phase_d;
      if (accept) begin
        discard_q <= 1'b0;
      end
      if (accept && !discard_q && phase_q == PH_DELTA_X) begin
        delta_x_q <= rx_byte_i;
      end
      if (accept && !discard_q && phase_q != PH_DELTA_X && phase_q != PH_DELTA_Y
          && rx_byte_i[HDR_SYNC]) begin
        header_q <= rx_byte_i;
      end
    end
  end

endmodule

@@ hw/rtl/pmct_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmct_fifo: packet queue
// Short first-in first-out queue of framed packets between the framer and
// the cursor back end.
// ----------------------------------------------------------------------------
module pmct_fifo import pmct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pkt_t push_pkt_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output pkt_t pop_pkt_o
);

  localparam int unsigned PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);

  pkt_t               mem_q [QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;

  assign full_o    = (count_q == CntBits'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign pop_pkt_o = mem_q[rd_ptr_q];

  function automatic logic [PtrBits-1:0] ptr_inc(input logic [PtrBits-1:0] p);
    return (p == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/pmct_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmct_back: cursor update
// Applies one packet's deltas to the cursor, clamps to the screen size and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module pmct_back import pmct_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CFG_BITS-1:0]  width_i,
  input  logic [CFG_BITS-1:0]  height_i,
  input  logic                 q_empty_i,
  input  pkt_t                 q_pkt_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CoordBits-1:0] cursor_x_o,
  output logic [CoordBits-1:0] cursor_y_o,
  output logic                 left_button_o,
  output logic                 right_button_o,
  output logic                 middle_button_o
);

  localparam int unsigned SumBits = CoordBits + 4;
  localparam int unsigned LimBits = ((CoordBits > CFG_BITS) ? CoordBits : CFG_BITS) + 1;

  logic                 valid_q;
  logic [CoordBits-1:0] pos_x_q, pos_x_d;
  logic [CoordBits-1:0] pos_y_q, pos_y_d;
  logic [2:0]           btn_q;

  logic signed [SumBits-1:0] sum_x, sum_y;
  logic [CoordBits-1:0]      max_x, max_y;

  // Largest coordinate for a size register: size minus one, with a size of
  // zero acting as one and sizes past the coordinate range capped.
  function automatic logic [CoordBits-1:0] coord_max(input logic [CFG_BITS-1:0] size);
    logic [LimBits-1:0] s;
    logic [LimBits-1:0] lim;
    logic [LimBits-1:0] m;
    s   = LimBits'(size);
    lim = LimBits'(1) << CoordBits;
    if (s == '0) begin
      m = '0;
    end else if (s > lim) begin
      m = lim - 1'b1;
    end else begin
      m = s - 1'b1;
    end
    return m[CoordBits-1:0];
  endfunction

  function automatic logic [CoordBits-1:0] clamp(
    input logic signed [SumBits-1:0] v,
    input logic [CoordBits-1:0]      mx
  );
    logic [CoordBits-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({{(SumBits-CoordBits){1'b0}}, mx})) begin
      r = mx;
    end else begin
      r = v[CoordBits-1:0];
    end
    return r;
  endfunction

  assign pop_o = !q_empty_i && (!valid_q || !out_stall_i);

  assign max_x = coord_max(width_i);
  assign max_y = coord_max(height_i);

  assign sum_x = $signed({{(SumBits-CoordBits){1'b0}}, pos_x_q})
               + $signed({{(SumBits-DELTA_BITS){q_pkt_i.dx[DELTA_BITS-1]}}, q_pkt_i.dx});
  // Y grows downward, so the mouse delta is subtracted.
  assign sum_y = $signed({{(SumBits-CoordBits){1'b0}}, pos_y_q})
               - $signed({{(SumBits-DELTA_BITS){q_pkt_i.dy[DELTA_BITS-1]}}, q_pkt_i.dy});

  assign pos_x_d = clamp(sum_x, max_x);
  assign pos_y_d = clamp(sum_y, max_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_x_q <= '0;
      pos_y_q <= '0;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        pos_x_q <= pos_x_d;
        pos_y_q <= pos_y_d;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      btn_q <= {q_pkt_i.middle, q_pkt_i.right, q_pkt_i.left};
    end
  end

  assign out_valid_o     = valid_q;
  assign cursor_x_o      = pos_x_q;
  assign cursor_y_o      = pos_y_q;
  assign left_button_o   = btn_q[0];
  assign right_button_o  = btn_q[1];
  assign middle_button_o = btn_q[2];

endmodule

@@ sim/pmct_cursor_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmct_cursor_checker: cursor tracker prediction and result check
// Follows every accepted mouse byte and screen size write, frames packets and
// keeps its own clamped cursor, then compares each accepted output word field
// by field against the oldest predicted cursor move.
// ----------------------------------------------------------------------------
module pmct_cursor_checker import pmct_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [CFG_BITS-1:0]       cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [7:0]                rx_byte_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [COORD_BITS_DEF-1:0] cursor_x_i,
  input  logic [COORD_BITS_DEF-1:0] cursor_y_i,
  input  logic                      left_button_i,
  input  logic                      right_button_i,
  input  logic                      middle_button_i,
  output int unsigned               bad_results_o,
  output int unsigned               moves_due_o
);

  localparam int SIGN_SPAN = 256;
  localparam int OVF_BOOST = 255;

  typedef struct packed {
    logic [COORD_BITS_DEF-1:0] x;
    logic [COORD_BITS_DEF-1:0] y;
    logic                      left;
    logic                      right;
    logic                      middle;
  } cursor_t;

  cursor_t             moves_due_q[$];
  phase_e              framer_phase = PH_HEADER;
  logic                skip_first   = 1'b1;
  logic [7:0]          hdr_byte     = '0;
  logic [7:0]          x_byte       = '0;
  int                  pos_x        = 0;
  int                  pos_y        = 0;
  logic [CFG_BITS-1:0] scr_w        = WIDTH_RST;
  logic [CFG_BITS-1:0] scr_h        = HEIGHT_RST;

  initial bad_results_o = 0;
  initial moves_due_o = 0;

  // Nine-bit two's complement delta, pushed a further step out on overflow.
  function automatic int mouse_delta(logic [7:0] mag, logic neg, logic ovf);
    int d;
    d = mag;
    if (neg) d = d - SIGN_SPAN;
    if (ovf) d = neg ? d - OVF_BOOST : d + OVF_BOOST;
    return d;
  endfunction

  // A zero size acts as one; sizes past the coordinate range saturate.
  function automatic int clamp_to_screen(int v, logic [CFG_BITS-1:0] size);
    int span;
    span = size;
    if (span < 1) span = 1;
    if (span > (1 << COORD_BITS_DEF)) span = 1 << COORD_BITS_DEF;
    if (v < 0) return 0;
    if (v > span - 1) return span - 1;
    return v;
  endfunction

  task automatic track_byte(logic [7:0] b);
    cursor_t mv;
    int      dx;
    int      dy;
    if (skip_first) begin
      skip_first = 1'b0;
    end else begin
      case (framer_phase)
        PH_DELTA_X: begin
          x_byte       = b;
          framer_phase = PH_DELTA_Y;
        end
        PH_DELTA_Y: begin
          dx = mouse_delta(x_byte, hdr_byte[HDR_XSIGN], hdr_byte[HDR_XOVF]);
          dy = mouse_delta(b, hdr_byte[HDR_YSIGN], hdr_byte[HDR_YOVF]);
          pos_x = clamp_to_screen(pos_x + dx, scr_w);
          pos_y = clamp_to_screen(pos_y - dy, scr_h);
          mv.x      = pos_x[COORD_BITS_DEF-1:0];
          mv.y      = pos_y[COORD_BITS_DEF-1:0];
          mv.left   = hdr_byte[HDR_LEFT];
          mv.right  = hdr_byte[HDR_RIGHT];
          mv.middle = hdr_byte[HDR_MIDDLE];
          moves_due_q.push_back(mv);
          framer_phase = PH_HEADER;
        end
        default: begin
          // Bytes without the sync bit never open a packet.
          if (b[HDR_SYNC]) begin
            hdr_byte     = b;
            framer_phase = PH_DELTA_X;
          end
        end
      endcase
    end
  endtask

  task automatic check_move();
    cursor_t want;
    if (moves_due_q.size() == 0) begin
      if (bad_results_o < 10) begin
        $display("%0t: cursor word with none due: x=%0d y=%0d l=%b r=%b m=%b", $time,
                 cursor_x_i, cursor_y_i, left_button_i, right_button_i, middle_button_i);
      end
      bad_results_o++;
    end else begin
      want = moves_due_q.pop_front();
      if (want.x !== cursor_x_i || want.y !== cursor_y_i || want.left !== left_button_i ||
          want.right !== right_button_i || want.middle !== middle_button_i) begin
        if (bad_results_o < 10) begin
          $display("%0t: cursor mismatch: expected x=%0d y=%0d l=%b r=%b m=%b", $time,
                   want.x, want.y, want.left, want.right, want.middle);
          $display("%0t:                  actual   x=%0d y=%0d l=%b r=%b m=%b", $time,
                   cursor_x_i, cursor_y_i, left_button_i, right_button_i, middle_button_i);
        end
        bad_results_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moves_due_q.delete();
      framer_phase = PH_HEADER;
      skip_first   = 1'b1;
      hdr_byte     = '0;
      x_byte       = '0;
      pos_x        = 0;
      pos_y        = 0;
      scr_w        = WIDTH_RST;
      scr_h        = HEIGHT_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SCREEN_WIDTH:  scr_w = cfg_wdata_i;
          CFG_SCREEN_HEIGHT: scr_h = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_move();
      if (in_valid_i && !in_stall_i) track_byte(rx_byte_i);
    end
    moves_due_o = moves_due_q.size();
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: mouse packet cursor tracker testbench
// Feeds directed and random mouse byte streams under a range of screen sizes,
// with random idle bursts on both channels and one long output hold-off that
// backs the block up; the checker predicts every cursor word.
// ----------------------------------------------------------------------------
module tb;
  import pmct_pkg::*;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic                      cfg_idx_i;
  logic [CFG_BITS-1:0]       cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [7:0]                rx_byte_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [COORD_BITS_DEF-1:0] cursor_x_o;
  logic [COORD_BITS_DEF-1:0] cursor_y_o;
  logic                      left_button_o;
  logic                      right_button_o;
  logic                      middle_button_o;

  int unsigned bad_results;
  int unsigned moves_due;

  logic send_idle_on = 1'b1;
  logic recv_idle_on = 1'b1;
  logic hold_req     = 1'b0;
  logic drift_x_neg  = 1'b0;
  logic drift_y_neg  = 1'b0;

  ps2_mouse_packet_cursor_tracker dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cursor_x_o      (cursor_x_o),
    .cursor_y_o      (cursor_y_o),
    .left_button_o   (left_button_o),
    .right_button_o  (right_button_o),
    .middle_button_o (middle_button_o)
  );

  pmct_cursor_checker chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cursor_x_i      (cursor_x_o),
    .cursor_y_i      (cursor_y_o),
    .left_button_i   (left_button_o),
    .right_button_i  (right_button_o),
    .middle_button_i (middle_button_o),
    .bad_results_o   (bad_results),
    .moves_due_o     (moves_due)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  // Output side: short random stall bursts, or one long hold when asked.
  initial begin
    int unsigned stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 80;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (recv_idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] pick_header();
    logic [7:0] h;
    h = 8'($urandom_range(0, 255));
    h[HDR_SYNC] = 1'b1;
    // Some packets push hard one way so the cursor reaches the screen edges.
    if ($urandom_range(0, 3) == 0) begin
      h[HDR_XSIGN] = drift_x_neg;
      h[HDR_XOVF]  = 1'b1;
      h[HDR_YSIGN] = drift_y_neg;
      h[HDR_YOVF]  = 1'b1;
    end
    return h;
  endfunction

  task automatic send_word(logic [7:0] b);
    int unsigned gap;
    if (send_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_packet();
    send_word(pick_header());
    send_word(8'($urandom_range(0, 255)));
    send_word(8'($urandom_range(0, 255)));
  endtask

  task automatic run_traffic(int unsigned target);
    int unsigned sent;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(8'($urandom_range(0, 255)));
      end else begin
        send_packet();
        sent += 3;
      end
    end
  endtask

  // Waits out every due cursor word plus the pipeline of a partial packet.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (moves_due != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_BITS-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [7:0] opening_q[$] = '{
      8'h08,                // dropped as the first byte
      8'hF7, 8'h00,         // no sync bit
      8'h4F, 8'hFF, 8'h00,  // all buttons, largest positive X with overflow
      8'h38, 8'h00, 8'h00,  // both signs with zero bytes
      8'hF8, 8'h01, 8'h80,  // both signs and overflows, X clamps at zero
      8'h88, 8'h7F, 8'hFF,  // Y overflow upwards
      8'h28, 8'h80, 8'h01,
      8'h08, 8'h00, 8'h00   // no movement
    };
    logic [CFG_BITS-1:0] widths[7]  = '{13'd1, 13'd0, 13'd8191, 13'd4096,
                                        13'd4097, 13'd640, 13'd1024};
    logic [CFG_BITS-1:0] heights[7] = '{13'd1, 13'd0, 13'd8191, 13'd4096,
                                        13'd5000, 13'd480, 13'd768};
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_SCREEN_WIDTH;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    widths[5]   = 13'($urandom_range(1, 4096));
    heights[5]  = 13'($urandom_range(1, 4096));
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening_q[i]) send_word(opening_q[i]);
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      send_idle_on = (ph == 0) || (ph < 6 && ph != 3 && $urandom_range(0, 1) == 1);
      recv_idle_on = (ph == 0) || (ph < 6 && $urandom_range(0, 1) == 1);
      drift_x_neg  = $urandom_range(0, 1);
      drift_y_neg  = $urandom_range(0, 1);
      write_reg(CFG_SCREEN_WIDTH, widths[ph]);
      write_reg(CFG_SCREEN_HEIGHT, heights[ph]);
      // The long hold lets the packet queue fill and stall the byte input.
      if (ph == 3) hold_req = 1'b1;
      run_traffic(100);
      wait_drained();
    end

    repeat (8) @(negedge clk_i);
    if (bad_results == 0 && moves_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
